// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the RTL of the terminal line store.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tlbs_pkg.sv =====
// Request codes, packing widths and constants for the terminal line store.
package tlbs_pkg;

  // Request kinds carried on s_tuser
  typedef enum logic [2:0] {
    REQ_CHAR        = 3'd0,
    REQ_SCROLL_UP   = 3'd1,
    REQ_SCROLL_DOWN = 3'd2,
    REQ_BOTTOM      = 3'd3,
    REQ_READ        = 3'd4
  } req_t;

  localparam int REQ_W      = 3;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  localparam logic [7:0] NEWLINE_CHAR = 8'd10;

endpackage

// ===== rtl/core/terminal_line_buffer_with_scrollback.sv =====
// Character terminal line store with scrollback, ring of lines in one memory.
//
//  Channel  | Dir | Payload                                              | Handshake
//  ---------+-----+------------------------------------------------------+----------------
//  s_*      | in  | tuser: req_type; tdata: char, amount, row, column    | s_tvalid/tready
//  m_*      | out | tdata: cell, cursor row/col, lines used, view offset | m_tvalid/tready
//
//  A printable character without scroll-out passes accept, evaluate, memory write and
//  result; a newline without scroll-out skips the memory write.
//  A line that scrolls out adds a wipe of the freed row, one cell a cycle.
//  Scrolls and unused codes skip the memory; a cell read adds the registered memory read.
//  After reset a clearing pass writes NUM_LINES * 2**clog2(LINE_LEN) cells, one a cycle;
//  s_tready stays low until it finishes.
//  The next transaction is taken while a result waits on m_tready; the result stage
//  holds the sequencer only when the output register is still full.
`include "assert_macros.svh"

module terminal_line_buffer_with_scrollback
  import tlbs_pkg::*;
#(
  parameter int NUM_LINES = 64,
  parameter int LINE_LEN  = 128
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [7:0] char_in, [15:8] scroll_amount, [21:16] read_row, [28:22] read_col, [31:29] zero
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // [2:0] req_type
  input  logic [REQ_W-1:0]      s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [7:0] cell_out, [13:8] cursor_row, [20:14] cursor_column, [27:21] lines_used,
  // [33:28] view_offset, [39:34] zero
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam int LW    = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
  localparam int CW    = (LINE_LEN > 1) ? $clog2(LINE_LEN) : 1;
  localparam int AW    = LW + CW;
  localparam int DEPTH = NUM_LINES * (2 ** CW);
  localparam int SW    = ((LW > 8) ? LW : 8) + 1;

  localparam logic [LW-1:0] LAST_LINE = LW'(NUM_LINES - 1);
  localparam logic [CW-1:0] LAST_COL  = CW'(LINE_LEN - 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [LW:0]   NUM_EXT   = (LW + 1)'(NUM_LINES);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_WIPE,
    S_WRITE,
    S_RDATA,
    S_DONE
  } state_t;

  state_t state;

  // Latched request
  logic [REQ_W-1:0] req_kind;
  logic [7:0]       req_char;
  logic [7:0]       req_amt;
  logic [5:0]       req_row;
  logic [6:0]       req_col;

  // Terminal state
  logic [LW-1:0] ring_top;
  logic [LW-1:0] cur_line;
  logic [CW-1:0] cur_col;
  logic [LW:0]   used_lines;
  logic [LW-1:0] scroll_pos;

  // Sweep counters and read bookkeeping
  logic [AW-1:0] clr_addr;
  logic [LW-1:0] wipe_row;
  logic [CW-1:0] wipe_col;
  logic          rd_ok;
  logic [7:0]    rd_cell;

  // Memory
  logic [7:0]    mem [DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  // Shared ring unit: logical line to physical row
  logic [LW-1:0] unit_line;
  logic [LW:0]   unit_sum;
  logic [LW-1:0] phys_row;

  // Evaluation helpers
  logic          is_newline;
  logic          wrap;
  logic          at_bottom;
  logic [LW-1:0] line_adv;
  logic [LW:0]   line_cnt;
  logic [LW-1:0] ring_next;
  logic [SW-1:0] up_sum;
  logic [SW-1:0] up_limit;
  logic          row_in_range;
  logic          col_in_range;

  assign s_tready = (state == S_IDLE);

  // Ring adder with one compare and subtract
  always_comb begin
    unit_line = (state == S_EXEC) ? LW'(req_row) : cur_line;
    unit_sum  = {1'b0, ring_top} + {1'b0, unit_line};
    phys_row  = (unit_sum >= NUM_EXT) ? LW'(unit_sum - NUM_EXT) : LW'(unit_sum);
  end

  // Character and scroll arithmetic
  always_comb begin
    is_newline   = (req_char == NEWLINE_CHAR);
    wrap         = is_newline || (cur_col >= LAST_COL);
    at_bottom    = (cur_line == LAST_LINE);
    line_adv     = at_bottom ? LAST_LINE : cur_line + 1'b1;
    line_cnt     = {1'b0, line_adv} + 1'b1;
    ring_next    = (ring_top == LAST_LINE) ? '0 : ring_top + 1'b1;
    up_sum       = SW'(scroll_pos) + SW'(req_amt);
    up_limit     = SW'(used_lines - 1'b1);
    row_in_range = (32'(req_row) < NUM_LINES);
    col_in_range = (32'(req_col) < LINE_LEN);
  end

  // Memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
      end
      S_WIPE: begin
        mem_we    = 1'b1;
        mem_waddr = {wipe_row, wipe_col};
      end
      S_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = {phys_row, cur_col};
        mem_wdata = req_char;
      end
      default: ;
    endcase
    mem_raddr = {phys_row, CW'(req_col)};
  end

  // Cell memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  // Sequencer, terminal state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      ring_top   <= '0;
      cur_line   <= '0;
      cur_col    <= '0;
      used_lines <= (LW + 1)'(1);
      scroll_pos <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        // Zero the whole store after reset
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            req_kind <= s_tuser;
            req_char <= s_tdata[7:0];
            req_amt  <= s_tdata[15:8];
            req_row  <= s_tdata[21:16];
            req_col  <= s_tdata[28:22];
            state    <= S_EXEC;
          end
        end
        S_EXEC: begin
          rd_cell <= '0;
          case (req_kind)
            REQ_CHAR: begin
              scroll_pos <= '0;
              if (wrap) begin
                cur_col  <= '0;
                cur_line <= line_adv;
                if (line_cnt > used_lines) begin
                  used_lines <= line_cnt;
                end
                if (at_bottom) begin
                  // Oldest line leaves the ring; its row becomes the new bottom
                  ring_top <= ring_next;
                  wipe_row <= ring_top;
                  wipe_col <= '0;
                  state    <= S_WIPE;
                end else if (!is_newline) begin
                  state <= S_WRITE;
                end else begin
                  state <= S_DONE;
                end
              end else begin
                state <= S_WRITE;
              end
            end
            REQ_SCROLL_UP: begin
              scroll_pos <= LW'((up_sum > up_limit) ? up_limit : up_sum);
              state      <= S_DONE;
            end
            REQ_SCROLL_DOWN: begin
              scroll_pos <= (SW'(req_amt) >= SW'(scroll_pos)) ? '0
                                                              : scroll_pos - LW'(req_amt);
              state      <= S_DONE;
            end
            REQ_BOTTOM: begin
              scroll_pos <= '0;
              state      <= S_DONE;
            end
            REQ_READ: begin
              rd_ok <= row_in_range && col_in_range;
              state <= S_RDATA;
            end
            default: state <= S_DONE;
          endcase
        end
        // Clear the freed row one cell a cycle
        S_WIPE: begin
          wipe_col <= wipe_col + 1'b1;
          if (wipe_col == LAST_COL) begin
            state <= is_newline ? S_DONE : S_WRITE;
          end
        end
        S_WRITE: begin
          cur_col <= cur_col + 1'b1;
          state   <= S_DONE;
        end
        S_RDATA: begin
          rd_cell <= rd_ok ? mem_rdata : '0;
          state   <= S_DONE;
        end
        // Load the result once the output register is free
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {6'd0, 6'(scroll_pos), 7'(used_lines), 7'(cur_col),
                         6'(cur_line), rd_cell};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks on the line and view bookkeeping, idle writes and request acceptance
  `ASSERT_IMPL(a_col_bound, clk, rst, 1'b1, cur_col <= LAST_COL, "cursor column out of line")
  `ASSERT_IMPL(a_view_bound, clk, rst, 1'b1, {1'b0, scroll_pos} < used_lines, "view past top")
  `ASSERT_IMPL(a_line_used, clk, rst, 1'b1, {1'b0, cur_line} < used_lines, "cursor past used")
  `ASSERT_IMPL(a_no_write_idle, clk, rst, state == S_IDLE, !mem_we, "memory write while idle")
  `ASSERT_NEXT(a_accept_exec, clk, rst, s_tvalid && s_tready, state == S_EXEC, "accept lost")

endmodule
